/* src/scl_pkg.sv */
// Shared types, codes and constants of the serial console line unit.
// No dependencies; scl_csr, the top level and the testbench import this package.
package scl_pkg;

    // Kind of an input item
    typedef enum logic [1:0] {
        FUNC_READ      = 2'd0,
        FUNC_WRITE     = 2'd1,
        FUNC_RX_BYTE   = 2'd2,
        FUNC_DEV_RESET = 2'd3
    } func_t;

    // Configuration register indexes
    localparam logic [1:0] CFG_BASE_ADDR = 2'd0;
    localparam logic [1:0] CFG_RX_VECTOR = 2'd1;

    // Register byte offsets from the base address
    localparam logic [15:0] OFF_RX_CSR = 16'd0;
    localparam logic [15:0] OFF_RX_BUF = 16'd2;
    localparam logic [15:0] OFF_TX_CSR = 16'd4;
    localparam logic [15:0] OFF_TX_BUF = 16'd6;

    // Status register bits
    localparam logic [7:0] ST_DONE_READY = 8'h80;
    localparam logic [7:0] ST_INT_EN     = 8'h40;
    localparam logic [7:0] ST_WR_MASK    = 8'h41;

    localparam logic [15:0] RX_EMPTY_WORD   = 16'hC000;
    localparam logic [7:0]  TX_STATUS_RESET = 8'h80;
    localparam logic [15:0] BASE_ADDR_RESET = 16'hFF70;
    localparam logic [8:0]  RX_VECTOR_RESET = 9'd48;
    localparam logic [9:0]  TX_VECTOR_STEP  = 10'd4;

    localparam int FIFO_DEPTH_DEFAULT = 16;

    typedef struct packed {
        func_t       func;
        logic [15:0] address;
        logic [15:0] wr_data;
        logic [7:0]  rx_byte;
    } item_t;

    typedef struct packed {
        logic [15:0] read_data;
        logic        tx_valid;
        logic [7:0]  tx_byte;
        logic        irq_valid;
        logic [9:0]  irq_vector;
    } result_t;

    // Pointer width for a FIFO of the given depth (at least one bit)
    function automatic int ptr_width(input int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

endpackage

/* src/scl_ram.sv */
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module scl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* src/scl_csr.sv */
// Register file and item decode of the serial console line unit: status and
// holding registers, FIFO pointers and fill count. Depends on scl_pkg.
module scl_csr
    import scl_pkg::*;
#(
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEFAULT,
    localparam int AW = ptr_width(FIFO_DEPTH),
    localparam int CW = $clog2(FIFO_DEPTH + 1)
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  item_t         item,
    input  logic [15:0]   base_addr,
    input  logic [8:0]    rx_vector,
    input  logic [7:0]    head_byte,
    output result_t       result,
    output logic          fifo_we,
    output logic [AW-1:0] fifo_waddr,
    output logic [7:0]    fifo_wdata,
    output logic [AW-1:0] rd_ptr_next
);

    logic [7:0]    rx_status_reg, rx_status_next;
    logic [15:0]   rx_holding_reg, rx_holding_next;
    logic [7:0]    tx_status_reg, tx_status_next;
    logic [15:0]   tx_holding_reg, tx_holding_next;
    logic [AW-1:0] rd_ptr_reg;
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic [15:0]   off;
    logic [9:0]    vec_rx;
    logic [9:0]    vec_tx;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        return (p == AW'(FIFO_DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    assign off    = item.address - base_addr;
    assign vec_rx = {1'b0, rx_vector};
    assign vec_tx = vec_rx + TX_VECTOR_STEP;

    always_comb begin
        rx_status_next  = rx_status_reg;
        rx_holding_next = rx_holding_reg;
        tx_status_next  = tx_status_reg;
        tx_holding_next = tx_holding_reg;
        rd_ptr_next     = rd_ptr_reg;
        wr_ptr_next     = wr_ptr_reg;
        fill_next       = fill_reg;
        result          = '0;
        fifo_we         = 1'b0;
        fifo_waddr      = wr_ptr_reg;
        fifo_wdata      = item.rx_byte;
        if (en) begin
            unique case (item.func)
                FUNC_READ: begin
                    if (off == OFF_RX_CSR) begin
                        result.read_data = {8'h00, rx_status_reg};
                    end else if (off == OFF_RX_BUF) begin
                        if (fill_reg != '0) begin
                            rx_holding_next = {8'h00, head_byte};
                            rd_ptr_next     = ptr_inc(rd_ptr_reg);
                            fill_next       = fill_reg - CW'(1);
                            if (fill_reg != CW'(1)) begin
                                rx_status_next = rx_status_reg | ST_DONE_READY;
                                if ((rx_status_reg & ST_INT_EN) != '0) begin
                                    result.irq_valid  = 1'b1;
                                    result.irq_vector = vec_rx;
                                end
                            end else begin
                                rx_status_next = rx_status_reg & ~ST_DONE_READY;
                            end
                        end else begin
                            rx_holding_next = RX_EMPTY_WORD;
                        end
                        result.read_data = rx_holding_next;
                    end else if (off == OFF_TX_CSR) begin
                        result.read_data = {8'h00, tx_status_reg};
                    end else if (off == OFF_TX_BUF) begin
                        result.read_data = tx_holding_reg;
                    end
                end
                FUNC_WRITE: begin
                    if (off == OFF_RX_CSR) begin
                        rx_status_next = (rx_status_reg & ~ST_WR_MASK)
                                       | (item.wr_data[7:0] & ST_WR_MASK);
                        if ((item.wr_data[7:0] & ST_INT_EN) != '0
                            && (rx_status_reg & ST_INT_EN) == '0
                            && (rx_status_reg & ST_DONE_READY) != '0) begin
                            result.irq_valid  = 1'b1;
                            result.irq_vector = vec_rx;
                        end
                    end else if (off == OFF_TX_CSR) begin
                        tx_status_next = (tx_status_reg & ~ST_WR_MASK)
                                       | (item.wr_data[7:0] & ST_WR_MASK);
                        if ((item.wr_data[7:0] & ST_INT_EN) != '0
                            && (tx_status_reg & ST_INT_EN) == '0
                            && (tx_status_reg & ST_DONE_READY) != '0) begin
                            result.irq_valid  = 1'b1;
                            result.irq_vector = vec_tx;
                        end
                    end else if (off == OFF_TX_BUF) begin
                        tx_holding_next = item.wr_data;
                        result.tx_valid = 1'b1;
                        result.tx_byte  = item.wr_data[7:0];
                        tx_status_next  = tx_status_reg | ST_DONE_READY;
                        if ((tx_status_reg & ST_INT_EN) != '0) begin
                            result.irq_valid  = 1'b1;
                            result.irq_vector = vec_tx;
                        end
                    end
                end
                FUNC_RX_BYTE: begin
                    if (fill_reg < CW'(FIFO_DEPTH)) begin
                        fifo_we        = 1'b1;
                        wr_ptr_next    = ptr_inc(wr_ptr_reg);
                        fill_next      = fill_reg + CW'(1);
                        rx_status_next = rx_status_reg | ST_DONE_READY;
                        if ((rx_status_reg & ST_INT_EN) != '0) begin
                            result.irq_valid  = 1'b1;
                            result.irq_vector = vec_rx;
                        end
                    end
                end
                FUNC_DEV_RESET: begin
                    rx_status_next = rx_status_reg & ~ST_INT_EN;
                    tx_status_next = TX_STATUS_RESET;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rx_status_reg  <= '0;
            rx_holding_reg <= '0;
            tx_status_reg  <= TX_STATUS_RESET;
            tx_holding_reg <= '0;
            rd_ptr_reg     <= '0;
            wr_ptr_reg     <= '0;
            fill_reg       <= '0;
        end else begin
            rx_status_reg  <= rx_status_next;
            rx_holding_reg <= rx_holding_next;
            tx_status_reg  <= tx_status_next;
            tx_holding_reg <= tx_holding_next;
            rd_ptr_reg     <= rd_ptr_next;
            wr_ptr_reg     <= wr_ptr_next;
            fill_reg       <= fill_next;
        end
    end

endmodule

/* src/serial_console_line_unit.sv */
// An input beat is taken into the input register; decode and register update then write
// its result into the result register, which holds it until m_tready takes it.
// Throughput: one beat per cycle while the result stream is not stalled; when
// empty, the input register lets a new beat in while a finished result waits on m_tready.
// Reset: aresetn (synchronous, active low) restores all control and status registers;
// the receive FIFO needs no clearing pass, since its fill count gates reads.
module serial_console_line_unit
    import scl_pkg::*;
#(
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // address[15:0], wr_data[31:16], rx_byte[39:32]
    input  logic [1:0]  s_tuser,   // func[1:0]
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // read_data[15:0], tx_byte[23:16], irq_vector[33:24], zero
    output logic [1:0]  m_tuser,   // tx_valid[0], irq_valid[1]
    // Configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int AW = ptr_width(FIFO_DEPTH);

    logic [15:0]   base_addr_reg;
    logic [8:0]    rx_vector_reg;

    logic          a_valid_reg;
    item_t         a_item_reg;
    logic          m_valid_reg;
    result_t       m_result_reg;

    logic          s_fire;
    logic          advance;
    result_t       result;
    logic          fifo_we;
    logic [AW-1:0] fifo_waddr;
    logic [7:0]    fifo_wdata;
    logic [AW-1:0] rd_ptr_next;
    logic [7:0]    ram_rdata;
    logic [7:0]    head_byte;

    // Bypass for a FIFO head that is written in the same cycle it is read
    logic          byp_valid_reg;
    logic [7:0]    byp_byte_reg;

    // Configuration: always ready; out-of-range indexes are dropped
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_addr_reg <= BASE_ADDR_RESET;
            rx_vector_reg <= RX_VECTOR_RESET;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == CFG_BASE_ADDR) begin
                base_addr_reg <= cfg_data;
            end else if (cfg_index == CFG_RX_VECTOR) begin
                rx_vector_reg <= cfg_data[8:0];
            end
        end
    end

    // Advance the held beat when the result slot is free or being drained;
    // take a new beat whenever the input register empties this cycle.
    assign advance  = a_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !a_valid_reg || advance;
    assign s_fire   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (s_tready) begin
            a_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            a_item_reg.func    <= func_t'(s_tuser);
            a_item_reg.address <= s_tdata[15:0];
            a_item_reg.wr_data <= s_tdata[31:16];
            a_item_reg.rx_byte <= s_tdata[39:32];
        end
    end

    // Fetch the FIFO head for the incoming beat: the address already accounts
    // for a pop by the beat leaving this cycle, and a push landing on that
    // same entry is caught by the bypass.
    scl_ram #(
        .WIDTH (8),
        .DEPTH (FIFO_DEPTH)
    ) u_fifo_ram (
        .aclk  (aclk),
        .we    (fifo_we),
        .waddr (fifo_waddr),
        .wdata (fifo_wdata),
        .re    (s_fire),
        .raddr (rd_ptr_next),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byp_valid_reg <= 1'b0;
        end else if (s_fire) begin
            byp_valid_reg <= fifo_we && (fifo_waddr == rd_ptr_next);
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            byp_byte_reg <= fifo_wdata;
        end
    end

    assign head_byte = byp_valid_reg ? byp_byte_reg : ram_rdata;

    scl_csr #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_csr (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (advance),
        .item        (a_item_reg),
        .base_addr   (base_addr_reg),
        .rx_vector   (rx_vector_reg),
        .head_byte   (head_byte),
        .result      (result),
        .fifo_we     (fifo_we),
        .fifo_waddr  (fifo_waddr),
        .fifo_wdata  (fifo_wdata),
        .rd_ptr_next (rd_ptr_next)
    );

    // Result register: load on advance, drop once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_result_reg <= result;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'b000000, m_result_reg.irq_vector, m_result_reg.tx_byte,
                       m_result_reg.read_data};
    assign m_tuser  = {m_result_reg.irq_valid, m_result_reg.tx_valid};

`ifndef SYNTHESIS
    // A transmitted character never comes with read data
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata[15:0] == 16'h0000)
        else $error("tx beat carries read data");

    // Without an interrupt the vector field stays zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[1] |-> m_tdata[33:24] == 10'd0)
        else $error("irq vector set without irq");

    // A result appears only from a held input beat
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(a_valid_reg))
        else $error("result without input beat");
`endif

endmodule

/* tb/sv/serial_console_line_unit_tb_pkg.sv */
// Scoreboard for the serial console line unit testbench: predicts each result beat.
// Depends on scl_pkg for the item, result and code definitions.
package scl_tb_pkg;
    import scl_pkg::*;

    class console_line_scoreboard;
        logic [15:0] base_addr;
        logic [8:0]  rx_vec;
        logic [7:0]  rx_csr;
        logic [15:0] rx_buf;
        logic [7:0]  tx_csr;
        logic [15:0] tx_buf;
        logic [7:0]  rx_fifo[FIFO_DEPTH_DEFAULT];
        int          fifo_rd;
        int          fifo_wr;
        int          fifo_fill;
        result_t     expected_results[$];
        int          mismatches;

        function new();
            base_addr  = BASE_ADDR_RESET;
            rx_vec     = RX_VECTOR_RESET;
            rx_csr     = 8'h00;
            rx_buf     = 16'h0000;
            tx_csr     = TX_STATUS_RESET;
            tx_buf     = 16'h0000;
            fifo_rd    = 0;
            fifo_wr    = 0;
            fifo_fill  = 0;
            mismatches = 0;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        // Out-of-range indexes are dropped by the block
        function void write_register(logic [1:0] index, logic [15:0] data);
            if (index == CFG_BASE_ADDR)
                base_addr = data;
            else if (index == CFG_RX_VECTOR)
                rx_vec = data[8:0];
        endfunction

        // Update the register image for one accepted item and queue its result
        function void note_item(item_t beat);
            result_t     want;
            logic [15:0] off;
            logic [7:0]  prev;
            logic [9:0]  tx_vec;
            want   = '0;
            off    = beat.address - base_addr;
            tx_vec = {1'b0, rx_vec} + TX_VECTOR_STEP;
            case (beat.func)
                FUNC_READ: begin
                    if (off == OFF_RX_CSR) begin
                        want.read_data = {8'h00, rx_csr};
                    end else if (off == OFF_RX_BUF) begin
                        if (fifo_fill > 0) begin
                            rx_buf    = {8'h00, rx_fifo[fifo_rd]};
                            fifo_rd   = (fifo_rd + 1) % FIFO_DEPTH_DEFAULT;
                            fifo_fill = fifo_fill - 1;
                            if (fifo_fill != 0) begin
                                rx_csr = rx_csr | ST_DONE_READY;
                                if ((rx_csr & ST_INT_EN) != 0) begin
                                    want.irq_valid  = 1'b1;
                                    want.irq_vector = {1'b0, rx_vec};
                                end
                            end else begin
                                rx_csr = rx_csr & ~ST_DONE_READY;
                            end
                        end else begin
                            rx_buf = RX_EMPTY_WORD;
                        end
                        want.read_data = rx_buf;
                    end else if (off == OFF_TX_CSR) begin
                        want.read_data = {8'h00, tx_csr};
                    end else if (off == OFF_TX_BUF) begin
                        want.read_data = tx_buf;
                    end
                end
                FUNC_WRITE: begin
                    if (off == OFF_RX_CSR) begin
                        prev   = rx_csr;
                        rx_csr = (rx_csr & ~ST_WR_MASK) | (beat.wr_data[7:0] & ST_WR_MASK);
                        if ((beat.wr_data[7:0] & ST_INT_EN) != 0 && (prev & ST_INT_EN) == 0
                            && (rx_csr & ST_DONE_READY) != 0) begin
                            want.irq_valid  = 1'b1;
                            want.irq_vector = {1'b0, rx_vec};
                        end
                    end else if (off == OFF_TX_CSR) begin
                        prev   = tx_csr;
                        tx_csr = (tx_csr & ~ST_WR_MASK) | (beat.wr_data[7:0] & ST_WR_MASK);
                        if ((beat.wr_data[7:0] & ST_INT_EN) != 0 && (prev & ST_INT_EN) == 0
                            && (tx_csr & ST_DONE_READY) != 0) begin
                            want.irq_valid  = 1'b1;
                            want.irq_vector = tx_vec;
                        end
                    end else if (off == OFF_TX_BUF) begin
                        tx_buf        = beat.wr_data;
                        want.tx_valid = 1'b1;
                        want.tx_byte  = beat.wr_data[7:0];
                        tx_csr        = tx_csr | ST_DONE_READY;
                        if ((tx_csr & ST_INT_EN) != 0) begin
                            want.irq_valid  = 1'b1;
                            want.irq_vector = tx_vec;
                        end
                    end
                end
                FUNC_RX_BYTE: begin
                    if (fifo_fill < FIFO_DEPTH_DEFAULT) begin
                        rx_fifo[fifo_wr] = beat.rx_byte;
                        fifo_wr   = (fifo_wr + 1) % FIFO_DEPTH_DEFAULT;
                        fifo_fill = fifo_fill + 1;
                        rx_csr    = rx_csr | ST_DONE_READY;
                        if ((rx_csr & ST_INT_EN) != 0) begin
                            want.irq_valid  = 1'b1;
                            want.irq_vector = {1'b0, rx_vec};
                        end
                    end
                end
                default: begin
                    rx_csr = rx_csr & ~ST_INT_EN;
                    tx_csr = TX_STATUS_RESET;
                end
            endcase
            expected_results.push_back(want);
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got,
                                    time now);
            if (got !== want) begin
                mismatches++;
                $display("%0t: %s mismatch: expected %h, actual %h", now, name, want, got);
            end
        endfunction

        function void check_result(result_t got, logic [5:0] pad, time now);
            result_t want;
            if (expected_results.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result beat: expected none, actual %h", now, got);
                return;
            end
            want = expected_results.pop_front();
            compare_field("read_data", want.read_data, got.read_data, now);
            compare_field("tx_valid", 16'(want.tx_valid), 16'(got.tx_valid), now);
            compare_field("tx_byte", 16'(want.tx_byte), 16'(got.tx_byte), now);
            compare_field("irq_valid", 16'(want.irq_valid), 16'(got.irq_valid), now);
            compare_field("irq_vector", 16'(want.irq_vector), 16'(got.irq_vector), now);
            compare_field("tdata padding", 16'h0000, 16'(pad), now);
        endfunction
    endclass

endpackage

/* tb/sv/serial_console_line_unit_test.sv */
// Top-level testbench of the serial console line unit: directed and random item streams.
// Depends on scl_pkg, scl_tb_pkg and the serial_console_line_unit RTL.
module serial_console_line_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import scl_pkg::*;
    import scl_tb_pkg::*;

    localparam int CLK_PERIOD    = 10;
    localparam int RESET_CYCLES  = 9;
    localparam int RANDOM_PHASES = 7;
    localparam int PHASE_ITEMS   = 150;
    // Slack to wait after every expected result has come back
    localparam int DRAIN_CYCLES  = 6;
    localparam int CYCLE_LIMIT   = 400000;
    // Register indexes the block does not implement
    localparam logic [1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [1:0] CFG_SPARE_HI = 2'd3;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;    // address[15:0], wr_data[31:16], rx_byte[39:32]
    logic [1:0]  s_tuser;    // func[1:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;    // read_data[15:0], tx_byte[23:16], irq_vector[33:24], zero
    logic [1:0]  m_tuser;    // tx_valid[0], irq_valid[1]
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    console_line_scoreboard sb;
    int unsigned            cycle_count = 0;
    int                     burst_left  = 1;

    serial_console_line_unit #(
        .FIFO_DEPTH(FIFO_DEPTH_DEFAULT)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    // Guard against a hung handshake
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Sample both streams at the rising edge; note the input first so the
    // predictor always runs ahead of the checker.
    always @(posedge aclk) begin
        item_t   in_beat;
        result_t out_beat;
        if (aresetn && s_tvalid && s_tready) begin
            in_beat.func    = func_t'(s_tuser);
            in_beat.address = s_tdata[15:0];
            in_beat.wr_data = s_tdata[31:16];
            in_beat.rx_byte = s_tdata[39:32];
            sb.note_item(in_beat);
        end
        if (aresetn && m_tvalid && m_tready) begin
            out_beat.read_data  = m_tdata[15:0];
            out_beat.tx_byte    = m_tdata[23:16];
            out_beat.irq_vector = m_tdata[33:24];
            out_beat.tx_valid   = m_tuser[0];
            out_beat.irq_valid  = m_tuser[1];
            sb.check_result(out_beat, m_tdata[39:34], $time);
        end
    end

    // Receiver backpressure: switch between always-ready, coin-flip, mostly-ready
    // and mostly-stalled stretches of random length.
    initial begin
        int mode;
        int span;
        m_tready = 1'b0;
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(10, 80);
            repeat (span) begin
                @(negedge aclk);
                case (mode)
                    0: m_tready = 1'b1;
                    1: m_tready = ($urandom_range(0, 1) == 1);
                    2: m_tready = ($urandom_range(0, 7) != 0);
                    default: m_tready = ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    function automatic item_t make_item(func_t func, logic [15:0] address,
                                        logic [15:0] wr_data, logic [7:0] rx_byte);
        item_t it;
        it.func    = func;
        it.address = address;
        it.wr_data = wr_data;
        it.rx_byte = rx_byte;
        return it;
    endfunction

    // Drive one beat and hold it until taken. Bursts end in a random gap,
    // sometimes of zero length so valid stays high across bursts.
    task automatic send_item(item_t it);
        int gap;
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tdata  = {it.rx_byte, it.wr_data, it.address};
        s_tuser  = it.func;
        do @(posedge aclk); while (!s_tready);
        burst_left--;
        if (burst_left <= 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            repeat (gap) begin
                @(negedge aclk);
                s_tvalid = 1'b0;
            end
            burst_left = $urandom_range(1, 24);
        end
    endtask

    // Drop valid, then wait until every expected result has come back
    task automatic settle();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_cfg(logic [1:0] index, logic [15:0] data);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = index;
        cfg_data  = data;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_register(index, data);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    initial begin
        logic [15:0] base;
        logic [8:0]  vec;
        logic [15:0] addr;
        func_t       func;
        int          rx_pct;
        int          rd_pct;
        int          roll;
        item_t       beat;

        sb        = new();
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed part at the reset configuration
        base = BASE_ADDR_RESET;
        // Reads with everything at reset; the empty receive buffer returns RX_EMPTY_WORD
        send_item(make_item(FUNC_READ, base + OFF_RX_CSR, 16'h0000, 8'h00));
        send_item(make_item(FUNC_READ, base + OFF_RX_BUF, 16'h0000, 8'h00));
        send_item(make_item(FUNC_READ, base + OFF_TX_CSR, 16'h0000, 8'h00));
        send_item(make_item(FUNC_READ, base + OFF_TX_BUF, 16'h0000, 8'h00));
        // Transmit with data extremes
        send_item(make_item(FUNC_WRITE, base + OFF_TX_BUF, 16'hFFFF, 8'h00));
        send_item(make_item(FUNC_WRITE, base + OFF_TX_BUF, 16'h0000, 8'hFF));
        // Enable receive interrupt while not done: no request
        send_item(make_item(FUNC_WRITE, base + OFF_RX_CSR, 16'hFFFF, 8'h00));
        send_item(make_item(FUNC_RX_BYTE, 16'hFFFF, 16'hFFFF, 8'h00));
        send_item(make_item(FUNC_RX_BYTE, 16'h0000, 16'h0000, 8'hFF));
        send_item(make_item(FUNC_RX_BYTE, base, 16'h0000, 8'hA5));
        // Pops that leave bytes behind keep done set, then the one that empties clears it
        send_item(make_item(FUNC_READ, base + OFF_RX_BUF, 16'h0000, 8'h00));
        send_item(make_item(FUNC_READ, base + OFF_RX_BUF, 16'h0000, 8'h00));
        send_item(make_item(FUNC_READ, base + OFF_RX_BUF, 16'h0000, 8'h00));
        send_item(make_item(FUNC_READ, base + OFF_RX_BUF, 16'h0000, 8'h00));
        // Newly set enable with done set raises a request
        send_item(make_item(FUNC_WRITE, base + OFF_RX_CSR, 16'h0000, 8'h00));
        send_item(make_item(FUNC_RX_BYTE, base, 16'h0000, 8'h5A));
        send_item(make_item(FUNC_WRITE, base + OFF_RX_CSR, 16'h0040, 8'h00));
        send_item(make_item(FUNC_WRITE, base + OFF_TX_CSR, 16'h0041, 8'h00));
        send_item(make_item(FUNC_WRITE, base + OFF_TX_BUF, 16'h1234, 8'h00));
        // Receive buffer write and unmatched addresses are ignored
        send_item(make_item(FUNC_WRITE, base + OFF_RX_BUF, 16'hFFFF, 8'h00));
        send_item(make_item(FUNC_READ, base + 16'd1, 16'h0000, 8'h00));
        send_item(make_item(FUNC_WRITE, base + 16'd8, 16'hFFFF, 8'h00));
        send_item(make_item(FUNC_READ, 16'h0000, 16'h0000, 8'h00));
        send_item(make_item(FUNC_DEV_RESET, 16'hFFFF, 16'hFFFF, 8'hFF));
        send_item(make_item(FUNC_READ, base + OFF_RX_CSR, 16'h0000, 8'h00));
        send_item(make_item(FUNC_READ, base + OFF_TX_CSR, 16'h0000, 8'h00));

        // Random phases, each with its own configuration and traffic mix
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            settle();
            case (ph)
                0: begin
                    base = 16'h0000;
                    vec  = 9'd0;
                end
                1: begin
                    base = 16'd65528;
                    vec  = 9'd508;
                end
                3: begin
                    base = BASE_ADDR_RESET;
                    vec  = RX_VECTOR_RESET;
                end
                default: begin
                    base = 16'($urandom_range(0, 65528));
                    vec  = 9'($urandom_range(0, 508));
                end
            endcase
            if (ph == 2) begin
                write_cfg(CFG_SPARE_LO, 16'($urandom_range(0, 65535)));
                write_cfg(CFG_SPARE_HI, 16'($urandom_range(0, 65535)));
            end
            write_cfg(CFG_BASE_ADDR, base);
            write_cfg(CFG_RX_VECTOR, {7'd0, vec});

            // Fill-heavy phases overrun the FIFO, drain-heavy ones hit the empty read
            case ($urandom_range(0, 2))
                0: begin
                    rx_pct = 60;
                    rd_pct = 15;
                end
                1: begin
                    rx_pct = 15;
                    rd_pct = 55;
                end
                default: begin
                    rx_pct = 35;
                    rd_pct = 35;
                end
            endcase

            repeat (PHASE_ITEMS) begin
                roll = $urandom_range(0, 99);
                if (roll < rx_pct)
                    func = FUNC_RX_BYTE;
                else if (roll < rx_pct + rd_pct)
                    func = FUNC_READ;
                else if (roll < 97)
                    func = FUNC_WRITE;
                else
                    func = FUNC_DEV_RESET;

                // Mostly hit a register, favoring the receive buffer; keep some noise
                roll = $urandom_range(0, 99);
                if (roll < 85) begin
                    case ($urandom_range(0, 4))
                        0: addr = base + OFF_RX_CSR;
                        1, 2: addr = base + OFF_RX_BUF;
                        3: addr = base + OFF_TX_CSR;
                        default: addr = base + OFF_TX_BUF;
                    endcase
                end else if (roll < 93) begin
                    addr = base + 16'($urandom_range(0, 4) * 2 + 1);
                end else begin
                    addr = 16'($urandom_range(0, 65535));
                end

                beat = make_item(func, addr, 16'($urandom_range(0, 65535)),
                                 8'($urandom_range(0, 255)));
                send_item(beat);
            end
        end

        settle();
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
